// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl top level, the only rtl file that includes them
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
	label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("assertion failed: invariant");

// consequent must hold on the edge after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/cus_pkg.sv =====
// shared constants, request codes and control structs of the cascade scheduler
// no dependencies
package cus_pkg;

	localparam int MAX_LEVELS           = 8;
	localparam int LEVEL_W              = $clog2(MAX_LEVELS);
	localparam int CNT_W                = LEVEL_W + 1;
	localparam int ENTER_W              = 13;
	localparam int FRAME_W              = 32;
	localparam int BUDGET_W             = 4;
	localparam int REQ_W                = 2;
	localparam int PROBES_PER_LEVEL_DEF = 4096;

	localparam logic [REQ_W-1:0] REQ_MARK   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SCHED  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

	// result of the shared compare unit
	typedef struct packed {
		logic dirt_gt;
		logic dirt_eq;
		logic age_lt;
	} cmp_res_t;

	// write controls into the per-cascade store
	typedef struct packed {
		logic               dirt_en;
		logic               age_en;
		logic [LEVEL_W-1:0] idx;
	} store_wr_t;

endpackage

// ===== rtl/cus_cmp.sv =====
// shared compare unit: dirt magnitude and update age of a candidate vs the best so far
// depends on cus_pkg
module cus_cmp
	import cus_pkg::*;
#(
	parameter int DIRT_W = 13
) (
	input  logic [DIRT_W-1:0]  a_dirt,
	input  logic [DIRT_W-1:0]  b_dirt,
	input  logic [FRAME_W-1:0] a_age,
	input  logic [FRAME_W-1:0] b_age,
	output cmp_res_t           res
);

	always_comb begin
		res.dirt_gt = a_dirt > b_dirt;
		res.dirt_eq = a_dirt == b_dirt;
		res.age_lt  = a_age < b_age;
	end

endmodule

// ===== rtl/cus_store.sv =====
// per-cascade dirt counts and last-update frames, one write and one read address
// depends on cus_pkg
module cus_store
	import cus_pkg::*;
#(
	parameter int DIRT_W = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  store_wr_t          wr,
	input  logic [DIRT_W-1:0]  wr_dirt,
	input  logic [FRAME_W-1:0] wr_age,
	input  logic [LEVEL_W-1:0] rd_idx,
	output logic [DIRT_W-1:0]  rd_dirt,
	output logic [FRAME_W-1:0] rd_age
);

	logic [DIRT_W-1:0]  dirt_q [MAX_LEVELS];
	logic [FRAME_W-1:0] age_q  [MAX_LEVELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				dirt_q[i] <= '0;
				age_q[i]  <= '0;
			end
		end else begin
			if (wr.dirt_en) begin
				dirt_q[wr.idx] <= wr_dirt;
			end
			if (wr.age_en) begin
				age_q[wr.idx] <= wr_age;
			end
		end
	end

	assign rd_dirt = dirt_q[rd_idx];
	assign rd_age  = age_q[rd_idx];

endmodule

// ===== rtl/cascade_update_scheduler.sv =====
// top level of the cascade update scheduler: sequencer, pick bookkeeping, output register
// depends on cus_pkg, cus_store, cus_cmp and assert_macros.svh
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: req_type[1:0]; tdata: cascade_index[2:0],
//                                  enter_cnt[15:3], budget[19:16]
// m_*      out  m_tvalid/m_tready  tdata: chosen_cascade[2:0]; tlast: last_pick
// cfg_*    in   cfg_valid/cfg_ready data: active_cascades[3:0]
//
// a mark in range reads, compares and writes back in its own state after the accept;
// finish, ignored marks and unused codes complete on the accept.
// a schedule request takes per pick a decide state, then a round-robin walk or a
// scan of the N active cascades (one cascade per cycle through the compare unit),
// then an emit state; a request gives at most N picks.
// reset clears control and store state only; active_cascades resets to 1.
// a stalled result holds in the output register and blocks the next pick only.
module cascade_update_scheduler
	import cus_pkg::*;
#(
	parameter int PROBES_PER_LEVEL = PROBES_PER_LEVEL_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // cascade_index, enter_cnt, budget, zero pad
	input  logic [1:0]  s_tuser,    // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // chosen_cascade, zero pad
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	`include "assert_macros.svh"

	localparam int ENTER_MAX = (1 << ENTER_W) - 1;
	localparam int DIRT_SAT  = (PROBES_PER_LEVEL > ENTER_MAX) ? ENTER_MAX : PROBES_PER_LEVEL;
	localparam int DIRT_W    = $clog2(DIRT_SAT + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MARK = 3'd1;
	localparam logic [2:0] ST_PICK = 3'd2;
	localparam logic [2:0] ST_RR   = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]            state_q;
	logic [3:0]            active_q;
	logic [FRAME_W-1:0]    frame_q;
	logic [LEVEL_W-1:0]    cursor_q;
	logic                  parity_q;
	logic [MAX_LEVELS-1:0] taken_q;
	logic [BUDGET_W-1:0]   picks_q;
	logic [BUDGET_W-1:0]   k_q;
	logic [LEVEL_W-1:0]    ptr_q;
	logic [LEVEL_W-1:0]    pick_q;
	logic [CNT_W-1:0]      scan_q;
	logic                  found_q;
	logic [DIRT_W-1:0]     best_dirt_q;
	logic [FRAME_W-1:0]    best_age_q;
	logic [LEVEL_W-1:0]    best_idx_q;
	logic [LEVEL_W-1:0]    idx_q;
	logic [DIRT_W-1:0]     ent_q;
	logic                  out_valid_q;
	logic [LEVEL_W-1:0]    out_idx_q;
	logic                  out_last_q;

	logic [REQ_W-1:0]    in_req;
	logic [LEVEL_W-1:0]  in_idx;
	logic [ENTER_W-1:0]  in_enter;
	logic [BUDGET_W-1:0] in_budget;
	logic [DIRT_W-1:0]   enter_sat;
	logic                in_fire;
	logic                in_range;
	logic [CNT_W-1:0]    count;
	logic                emit_go;
	logic                emit_last;
	logic [LEVEL_W-1:0]  scan_idx;
	logic                scan_take;
	logic [LEVEL_W-1:0]  ptr_next;
	logic [LEVEL_W-1:0]  cursor_next;
	logic [LEVEL_W-1:0]  rr_start;

	store_wr_t          st_wr;
	logic [DIRT_W-1:0]  st_wr_dirt;
	logic [LEVEL_W-1:0] st_rd_idx;
	logic [DIRT_W-1:0]  st_rd_dirt;
	logic [FRAME_W-1:0] st_rd_age;
	logic [DIRT_W-1:0]  cmp_a_dirt;
	logic [DIRT_W-1:0]  cmp_b_dirt;
	cmp_res_t           cmp_res;

	assign in_req    = s_tuser[1:0];
	assign in_idx    = s_tdata[2:0];
	assign in_enter  = s_tdata[15:3];
	assign in_budget = s_tdata[19:16];
	assign in_fire   = s_tvalid && s_tready;
	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;

	// out-of-range register values count as the nearest legal value
	always_comb begin
		if (active_q == 4'd0) begin
			count = CNT_W'(1);
		end else if (32'(active_q) > 32'(MAX_LEVELS)) begin
			count = CNT_W'(MAX_LEVELS);
		end else begin
			count = CNT_W'(active_q);
		end
	end

	assign in_range  = {1'b0, in_idx} < count;
	assign enter_sat = (32'(in_enter) > 32'(DIRT_SAT)) ? DIRT_W'(DIRT_SAT) : DIRT_W'(in_enter);

	assign scan_idx  = scan_q[LEVEL_W-1:0];
	assign rr_start  = ({1'b0, cursor_q} < count) ? cursor_q : '0;
	assign ptr_next  = ({1'b0, ptr_q} + CNT_W'(1) == count) ? '0 : ptr_q + LEVEL_W'(1);
	assign cursor_next = ({1'b0, pick_q} + CNT_W'(1) == count) ? '0 : pick_q + LEVEL_W'(1);

	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	assign emit_last = (k_q + BUDGET_W'(1)) == picks_q;

	// store port: mark writes back after its compare, finish writes on accept
	always_comb begin
		st_wr.dirt_en = 1'b0;
		st_wr.age_en  = 1'b0;
		st_wr.idx     = in_idx;
		st_wr_dirt    = '0;
		if (state_q == ST_MARK) begin
			st_wr.idx     = idx_q;
			st_wr.dirt_en = cmp_res.dirt_gt;
			st_wr_dirt    = ent_q;
		end else if (in_fire && in_req == REQ_FINISH && in_range) begin
			st_wr.dirt_en = 1'b1;
			st_wr.age_en  = 1'b1;
		end
	end

	assign st_rd_idx  = (state_q == ST_MARK) ? idx_q : scan_idx;
	assign cmp_a_dirt = (state_q == ST_MARK) ? ent_q : st_rd_dirt;
	assign cmp_b_dirt = (state_q == ST_MARK) ? st_rd_dirt : best_dirt_q;

	// dirt ties go to the older update; equal ages keep the lower index
	assign scan_take = !taken_q[scan_idx] &&
		(!found_q || cmp_res.dirt_gt || (cmp_res.dirt_eq && cmp_res.age_lt));

	cus_store #(
		.DIRT_W(DIRT_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (st_wr),
		.wr_dirt (st_wr_dirt),
		.wr_age  (frame_q),
		.rd_idx  (st_rd_idx),
		.rd_dirt (st_rd_dirt),
		.rd_age  (st_rd_age)
	);

	cus_cmp #(
		.DIRT_W(DIRT_W)
	) u_cmp (
		.a_dirt (cmp_a_dirt),
		.b_dirt (cmp_b_dirt),
		.a_age  (st_rd_age),
		.b_age  (best_age_q),
		.res    (cmp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			frame_q  <= '0;
			cursor_q <= '0;
			parity_q <= 1'b0;
			taken_q  <= '0;
			picks_q  <= '0;
			k_q      <= '0;
			found_q  <= 1'b0;
			scan_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_req == REQ_MARK && in_range) begin
							state_q <= ST_MARK;
						end else if (in_req == REQ_SCHED) begin
							frame_q <= frame_q + FRAME_W'(1);
							taken_q <= '0;
							k_q     <= '0;
							if (in_budget == '0) begin
								picks_q <= BUDGET_W'(1);
							end else if (32'(in_budget) > 32'(count)) begin
								picks_q <= BUDGET_W'(count);
							end else begin
								picks_q <= in_budget;
							end
							state_q <= ST_PICK;
						end
					end
				end
				ST_MARK: begin
					state_q <= ST_IDLE;
				end
				ST_PICK: begin
					if (!parity_q) begin
						state_q <= ST_RR;
					end else begin
						scan_q  <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_RR: begin
					if (!taken_q[ptr_q]) begin
						state_q <= ST_EMIT;
					end
				end
				ST_SCAN: begin
					if (scan_q == count) begin
						state_q <= ST_EMIT;
					end else begin
						if (scan_take) begin
							found_q <= 1'b1;
						end
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						taken_q[pick_q] <= 1'b1;
						parity_q        <= ~parity_q;
						k_q             <= k_q + BUDGET_W'(1);
						if (!parity_q) begin
							cursor_q <= cursor_next;
						end
						state_q <= emit_last ? ST_IDLE : ST_PICK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire) begin
			idx_q <= in_idx;
			ent_q <= enter_sat;
		end
		if (state_q == ST_PICK) begin
			ptr_q <= rr_start;
		end else if (state_q == ST_RR) begin
			if (taken_q[ptr_q]) begin
				ptr_q <= ptr_next;
			end else begin
				pick_q <= ptr_q;
			end
		end
		if (state_q == ST_SCAN) begin
			if (scan_q == count) begin
				pick_q <= best_idx_q;
			end else if (scan_take) begin
				best_dirt_q <= st_rd_dirt;
				best_age_q  <= st_rd_age;
				best_idx_q  <= scan_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_idx_q  <= pick_q;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8 - LEVEL_W){1'b0}}, out_idx_q};
	assign m_tlast  = out_last_q;

	// round-robin walk always has a free cascade ahead of it
	`ASSERT_ALWAYS(a_rr_free, clk, arst_n,
		(state_q != ST_RR) || ($countones(taken_q) < int'(count)))
	// never emit more picks than the clamped budget
	`ASSERT_ALWAYS(a_emit_count, clk, arst_n, (state_q != ST_EMIT) || (k_q < picks_q))
	// a pick names an active, not yet chosen cascade
	`ASSERT_ALWAYS(a_pick_ok, clk, arst_n,
		(state_q != ST_EMIT) || (({1'b0, pick_q} < count) && !taken_q[pick_q]))
	// the final pick returns the sequencer to idle
	`ASSERT_NEXT(a_last_idle, clk, arst_n, emit_go && emit_last,
		(state_q == ST_IDLE) && m_tvalid && m_tlast)

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking bench for cascade_update_scheduler: directed requests, then random frames
// keeps its own scheduler state to predict every pick; depends on cus_pkg and the rtl top
module testbench;
	import cus_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned PROBE_CAP     = PROBES_PER_LEVEL_DEF;
	localparam int          SETTLE_CYCLES = 120;
	localparam int          LIMIT_CYCLES  = 1000000;

	typedef struct packed {
		logic [REQ_W-1:0]    kind;
		logic [LEVEL_W-1:0]  idx;
		logic [ENTER_W-1:0]  enter;
		logic [BUDGET_W-1:0] budget;
	} cascade_req_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] cascade;
		logic               last;
	} pick_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // cascade_index, enter_cnt, budget, zero pad
	logic [1:0]  s_tuser   = '0;   // req_type
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // chosen_cascade, zero pad
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data  = '0;

	cascade_update_scheduler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// scheduler state as the bench expects it
	logic [3:0]         active_reg;
	logic [ENTER_W-1:0] dirt_m [MAX_LEVELS];
	logic [FRAME_W-1:0] stamp_m [MAX_LEVELS];
	logic [FRAME_W-1:0] frame_m;
	logic [LEVEL_W-1:0] cursor_m;
	logic               parity_m;

	pick_t              pending_picks[$];
	logic [LEVEL_W-1:0] recent_picks[$];

	int error_count   = 0;
	int requests_sent = 0;
	int picks_seen    = 0;
	int settings_used = 0;
	int burst_left    = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * 20);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	function automatic int unsigned levels_in_use();
		if (active_reg < 1) return 1;
		if (active_reg > MAX_LEVELS) return MAX_LEVELS;
		return active_reg;
	endfunction

	task automatic reset_model();
		active_reg = 4'd1;
		frame_m    = '0;
		cursor_m   = '0;
		parity_m   = 1'b0;
		foreach (dirt_m[i]) begin
			dirt_m[i]  = '0;
			stamp_m[i] = '0;
		end
	endtask

	task automatic apply_request(input cascade_req_t r);
		int unsigned n, picks, p, steps, e, k, i;
		logic [MAX_LEVELS-1:0] taken;
		bit found;
		pick_t item;
		n = levels_in_use();
		case (r.kind)
			REQ_MARK: begin
				if (r.idx < n) begin
					e = (r.enter > PROBE_CAP) ? PROBE_CAP : r.enter;
					if (e > dirt_m[r.idx]) dirt_m[r.idx] = ENTER_W'(e);
				end
			end
			REQ_FINISH: begin
				if (r.idx < n) begin
					dirt_m[r.idx]  = '0;
					stamp_m[r.idx] = frame_m;
				end
			end
			REQ_SCHED: begin
				frame_m = frame_m + FRAME_W'(1);
				picks = r.budget;
				if (picks < 1) picks = 1;
				if (picks > n) picks = n;
				taken = '0;
				recent_picks.delete();
				for (k = 0; k < picks; k++) begin
					if (!parity_m) begin
						// round-robin slot; a cursor at or beyond the active count restarts at 0
						p = (cursor_m < n) ? cursor_m : 0;
						steps = 0;
						while (taken[p] && steps < n) begin
							p = (p + 1) % n;
							steps++;
						end
						cursor_m = LEVEL_W'((p + 1) % n);
					end else begin
						// dirtiest free cascade, older stamp then lower index on ties
						found = 1'b0;
						p = 0;
						for (i = 0; i < n; i++) begin
							if (taken[i]) continue;
							if (!found || dirt_m[i] > dirt_m[p] ||
							    (dirt_m[i] == dirt_m[p] && stamp_m[i] < stamp_m[p])) begin
								p = i;
								found = 1'b1;
							end
						end
					end
					parity_m = ~parity_m;
					taken[p] = 1'b1;
					item.cascade = p[LEVEL_W-1:0];
					item.last    = (k + 1 == picks);
					pending_picks.insert(pending_picks.size(), item);
					recent_picks.insert(recent_picks.size(), p[LEVEL_W-1:0]);
				end
			end
			default: ;
		endcase
	endtask

	// requester works in bursts; valid stays high across back-to-back requests
	task automatic send_request(input cascade_req_t r);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.kind;
		s_tdata  <= {4'b0, r.budget, r.enter, r.idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_request(r);
		requests_sent++;
		burst_left--;
		if (burst_left == 0) s_tvalid <= 1'b0;
	endtask

	task automatic send_fields(input logic [REQ_W-1:0] kind, input int unsigned idx,
	                           input int unsigned enter, input int unsigned budget);
		cascade_req_t r;
		r.kind   = kind;
		r.idx    = LEVEL_W'(idx);
		r.enter  = ENTER_W'(enter);
		r.budget = BUDGET_W'(budget);
		send_request(r);
	endtask

	// drop valid, let all picks drain, then allow for a mark still in flight
	task automatic wait_idle();
		if (burst_left != 0) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
		end
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_levels(input logic [3:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		active_reg = value;
		settings_used++;
	endtask

	function automatic int unsigned random_enter();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 3) return $urandom_range(0, 15);
		if (sel == 3) return PROBE_CAP;
		if (sel == 4) return $urandom_range(PROBE_CAP, 8191);
		return $urandom_range(0, PROBE_CAP);
	endfunction

	always @(posedge clk) begin : check_picks
		pick_t want;
		if (arst_n && m_tvalid && m_tready) begin
			picks_seen++;
			if (pending_picks.size() == 0) begin
				report_mismatch($sformatf("pick %0d with no request waiting", m_tdata));
			end else begin
				want = pending_picks.pop_front();
				if (m_tdata !== {5'b0, want.cascade})
					report_mismatch($sformatf("chosen_cascade %0d, expected %0d",
						m_tdata, want.cascade));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last_pick %0b, expected %0b", m_tlast, want.last));
			end
		end
	end

	// result side stalls in modes of its own: open, coin flip, sparse, periodic
	int ready_mode = 0;
	int ready_hold = 0;
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_hold = $urandom_range(50, 300);
		end else begin
			ready_hold--;
		end
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= ((ready_hold % 16) < 3);
		endcase
	end

	// single cascade out of reset: every budget gives cascade 0
	task automatic test_after_reset();
		send_fields(REQ_SCHED, 0, 0, 0);
		send_fields(REQ_SCHED, 7, 8191, 15);
		send_fields(REQ_MARK, 1, 100, 0);
		send_fields(REQ_FINISH, 0, 0, 0);
	endtask

	// register above and below range, entering counts at and past saturation
	task automatic test_register_extremes();
		write_levels(4'd15);
		send_fields(REQ_MARK, 7, 8191, 0);
		send_fields(REQ_MARK, 0, PROBE_CAP, 0);
		send_fields(REQ_MARK, 3, PROBE_CAP - 1, 0);
		send_fields(REQ_MARK, 5, 0, 0);
		send_fields(REQ_MARK, 3, 1, 0);
		send_fields(REQ_SCHED, 0, 0, 15);
		send_fields(REQ_FINISH, 7, 0, 0);
		send_fields(REQ_FINISH, 0, 0, 0);
		send_fields(REQ_UNUSED, 7, 8191, 15);
		send_fields(REQ_SCHED, 0, 0, 0);
		send_fields(REQ_SCHED, 0, 0, 3);
		write_levels(4'd0);
		send_fields(REQ_MARK, 2, 500, 0);
		send_fields(REQ_FINISH, 4, 0, 0);
		send_fields(REQ_SCHED, 0, 0, 2);
	endtask

	// move the cursor high, then shrink the register under it
	task automatic test_stale_cursor();
		write_levels(4'd8);
		send_fields(REQ_SCHED, 0, 0, 6);
		send_fields(REQ_SCHED, 0, 0, 1);
		send_fields(REQ_SCHED, 0, 0, 1);
		write_levels(4'd2);
		send_fields(REQ_MARK, 7, 300, 0);
		send_fields(REQ_SCHED, 0, 0, 2);
	endtask

	// mostly well-formed frames: marks, one schedule, finishes for what was picked
	task automatic test_random_frames();
		int unsigned settings[12] = '{8, 3, 15, 0, 1, 6, 8, 2, 7, 4, 9, 5};
		int unsigned n, marks, phase_items;
		cascade_req_t r;
		foreach (settings[s]) begin
			write_levels(4'(settings[s]));
			n = levels_in_use();
			phase_items = 0;
			while (phase_items < 36) begin
				if ($urandom_range(0, 4) != 0) begin
					marks = $urandom_range(0, 4);
					repeat (marks) begin
						r.kind   = REQ_MARK;
						r.idx    = LEVEL_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
						                                               : $urandom_range(0, n - 1));
						r.enter  = ENTER_W'(random_enter());
						r.budget = BUDGET_W'($urandom);
						send_request(r);
						phase_items++;
					end
					r.kind   = REQ_SCHED;
					r.idx    = LEVEL_W'($urandom);
					r.enter  = ENTER_W'($urandom);
					r.budget = BUDGET_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
					                                                : $urandom_range(0, n + 1));
					send_request(r);
					phase_items++;
					foreach (recent_picks[j]) begin
						if ($urandom_range(0, 3) != 0) begin
							r.kind   = REQ_FINISH;
							r.idx    = recent_picks[j];
							r.enter  = ENTER_W'($urandom);
							r.budget = BUDGET_W'($urandom);
							send_request(r);
							phase_items++;
						end
					end
				end else begin
					r.kind   = REQ_W'($urandom_range(0, 3));
					r.idx    = LEVEL_W'($urandom_range(0, 7));
					r.enter  = ENTER_W'(random_enter());
					r.budget = BUDGET_W'($urandom_range(0, 15));
					send_request(r);
					phase_items++;
				end
			end
		end
	endtask

	initial begin
		reset_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_register_extremes();
		test_stale_cursor();
		test_random_frames();
		wait_idle();
		$display("covered %0d requests and %0d picks over %0d register settings,",
			requests_sent, picks_seen, settings_used);
		$display("including out-of-range register values, saturation and a stale cursor");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cus_pkg.sv
rtl/cus_cmp.sv
rtl/cus_store.sv
rtl/cascade_update_scheduler.sv
tb/sv/testbench.sv
